/* sv/skhc_pkg.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip: shared package
// Constants, the configuration bundle, the divider stage payload and the
// conversions between signed samples and the unsigned unit interval.
// ----------------------------------------------------------------------------
package skhc_pkg;

	localparam int SAMPLE_BITS = 16;

	// Unit interval: HB fraction bits, values up to 1.0 inclusive need UW bits.
	localparam int HB = 16;
	localparam int UW = HB + 1;
	localparam logic [UW-1:0] UNIT_ONE = UW'(1) << HB;
	localparam logic [UW:0]   UNIT_THREE = (UW + 1)'(3) << HB;

	localparam int REG_BITS = 16;
	localparam logic [REG_BITS-1:0] REG_ONE = REG_BITS'(1) << (REG_BITS - 1);

	localparam int IDX_BITS = 2;
	localparam logic [IDX_BITS-1:0] REG_MODE = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_THR  = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_SOFT = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_STR  = IDX_BITS'(3);

	localparam logic [REG_BITS-1:0] THR_RESET  = REG_BITS'(16384);
	localparam logic [REG_BITS-1:0] SOFT_RESET = REG_BITS'(3277);
	localparam logic [REG_BITS-1:0] STR_RESET  = REG_BITS'(32768);

	// Restoring divider: quotient bits resolved per stage and number of stages.
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = HB / DIV_STEP;

	// How the smoothstep ramp value is obtained.
	localparam logic [1:0] T_ZERO = 2'd0;
	localparam logic [1:0] T_ONE  = 2'd1;
	localparam logic [1:0] T_DIV  = 2'd2;

	// Sample rescaling between SAMPLE_BITS and the HB-bit unit interval.
	localparam int DOWN = (SAMPLE_BITS > HB) ? SAMPLE_BITS - HB : 0;
	localparam int UP   = (SAMPLE_BITS < HB) ? HB - SAMPLE_BITS : 0;
	localparam int BW   = SAMPLE_BITS + HB;
	localparam int OW   = UW + DOWN + 1;
	localparam logic [OW-1:0] RND = OW'((1 << UP) >> 1);
	localparam logic [SAMPLE_BITS-1:0] HALF_CODE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] MAX_CODE  = HALF_CODE - SAMPLE_BITS'(1);

	typedef struct packed {
		logic                 mode;
		logic [UW-1:0]        thr;
		logic [HB-1:0]        soft_w;
		logic [UW-1:0]        den;
		logic signed [UW:0]   e0;
		logic [UW-1:0]        str;
	} cfg_t;

	typedef struct packed {
		logic [HB-1:0] h;
		logic [1:0]    tcase;
		logic [UW-1:0] rem;
		logic [HB-1:0] q;
	} div_t;

	function automatic logic [HB-1:0] to_unit(input logic [SAMPLE_BITS-1:0] s);
		logic [BW-1:0] biased;
		biased = BW'(s ^ HALF_CODE);
		return HB'((biased >> DOWN) << UP);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [UW-1:0] r);
		logic [OW-1:0] u;
		if (UP > 0) begin
			u = (OW'(r) + RND) >> UP;
		end else begin
			u = OW'(r) << DOWN;
		end
		// Anything at or above the full code range saturates positive.
		if (|u[OW-1:SAMPLE_BITS]) begin
			return MAX_CODE;
		end
		return u[SAMPLE_BITS-1:0] ^ HALF_CODE;
	endfunction

endpackage

/* sv/skhc_cfg.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip: configuration registers
// Holds the four registers and derives the saturated, doubled working values.
// ----------------------------------------------------------------------------
module skhc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [skhc_pkg::IDX_BITS-1:0]  wr_index,
	input  logic [skhc_pkg::REG_BITS-1:0]  wr_data,
	output skhc_pkg::cfg_t                 cfg
);
	import skhc_pkg::*;

	logic                mode_q;
	logic [REG_BITS-1:0] thr_q;
	logic [REG_BITS-1:0] soft_q;
	logic [REG_BITS-1:0] str_q;
	logic [REG_BITS-1:0] thr_sat;
	logic [REG_BITS-1:0] soft_sat;
	logic [REG_BITS-1:0] str_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			thr_q  <= THR_RESET;
			soft_q <= SOFT_RESET;
			str_q  <= STR_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE: mode_q <= wr_data[0];
				REG_THR:  thr_q  <= wr_data;
				REG_SOFT: soft_q <= wr_data;
				REG_STR:  str_q  <= wr_data;
				default: ;
			endcase
		end
	end

	assign thr_sat  = (thr_q  > REG_ONE) ? REG_ONE : thr_q;
	assign soft_sat = (soft_q > REG_ONE) ? REG_ONE : soft_q;
	assign str_sat  = (str_q  > REG_ONE) ? REG_ONE : str_q;

	always_comb begin
		cfg.mode   = mode_q;
		cfg.thr    = {thr_sat, 1'b0};
		cfg.soft_w = soft_sat;
		cfg.den    = {soft_sat, 1'b0};
		cfg.str    = {str_sat, 1'b0};
		// Lower window edge may fall below zero; it is kept signed.
		cfg.e0     = $signed({1'b0, thr_sat, 1'b0}) - $signed({2'b00, soft_sat});
	end

endmodule

/* sv/skhc_div_stage.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip: divider stage
// One register stage of the restoring divider, resolving DIV_STEP quotient
// bits of the smoothstep ramp position.
// ----------------------------------------------------------------------------
module skhc_div_stage (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_in,
	input  skhc_pkg::div_t                    d_in,
	input  logic [skhc_pkg::UW-1:0]           den,
	output logic                              v_out,
	output skhc_pkg::div_t                    d_out
);
	import skhc_pkg::*;

	div_t d_nxt;

	always_comb begin
		logic [UW:0] sh;
		d_nxt = d_in;
		for (int i = 0; i < DIV_STEP; i++) begin
			sh = {d_nxt.rem, 1'b0};
			if (sh >= {1'b0, den}) begin
				d_nxt.rem = UW'(sh - {1'b0, den});
				d_nxt.q   = {d_nxt.q[HB-2:0], 1'b1};
			end else begin
				d_nxt.rem = sh[UW-1:0];
				d_nxt.q   = {d_nxt.q[HB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out <= d_nxt;
	end

endmodule

/* sv/skhc_weight.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip: smoothstep weight
// Maps the sample to the unit interval, locates it in the knee window,
// divides out the ramp position and evaluates t*t*(3-2t).
// ----------------------------------------------------------------------------
module skhc_weight (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                v_in,
	input  logic [skhc_pkg::SAMPLE_BITS-1:0]    sample,
	input  skhc_pkg::cfg_t                      cfg,
	output logic                                v_out,
	output logic [skhc_pkg::HB-1:0]             h_out,
	output logic [skhc_pkg::UW-1:0]             w_out
);
	import skhc_pkg::*;

	logic [HB-1:0]      h0;
	logic signed [UW:0] rel_pos;
	div_t               d0;
	logic               v_s1;
	div_t               d_s1;

	logic               dv   [DIV_STAGES+1];
	div_t               dd   [DIV_STAGES+1];

	logic [UW-1:0]      t;
	logic               v_s6;
	logic [HB-1:0]      h_s6;
	logic [UW-1:0]      t_s6;
	logic [2*UW-1:0]    t2_s6;
	logic [UW:0]        k;
	logic [3*UW:0]      prod;

	assign h0      = to_unit(sample);
	assign rel_pos = $signed({2'b00, h0}) - cfg.e0;

	always_comb begin
		d0.h   = h0;
		d0.q   = '0;
		d0.rem = rel_pos[UW-1:0];
		if (cfg.soft_w == '0) begin
			// No softness: a hard step at the threshold.
			d0.tcase = ({1'b0, h0} >= cfg.thr) ? T_ONE : T_ZERO;
		end else if (rel_pos <= 0) begin
			d0.tcase = T_ZERO;
		end else if (rel_pos >= $signed({1'b0, cfg.den})) begin
			d0.tcase = T_ONE;
		end else begin
			d0.tcase = T_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= d0;
	end

	assign dv[0] = v_s1;
	assign dd[0] = d_s1;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		skhc_div_stage u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.v_in  (dv[g]),
			.d_in  (dd[g]),
			.den   (cfg.den),
			.v_out (dv[g+1]),
			.d_out (dd[g+1])
		);
	end

	always_comb begin
		case (dd[DIV_STAGES].tcase)
			T_ZERO:  t = '0;
			T_ONE:   t = UNIT_ONE;
			default: t = {1'b0, dd[DIV_STAGES].q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_out <= 1'b0;
		end else begin
			v_s6  <= dv[DIV_STAGES];
			v_out <= v_s6;
		end
	end

	assign k    = UNIT_THREE - {t_s6, 1'b0};
	assign prod = t2_s6 * k;

	always_ff @(posedge clk) begin
		h_s6  <= dd[DIV_STAGES].h;
		t_s6  <= t;
		t2_s6 <= t * t;
		h_out <= h_s6;
		w_out <= prod[2*HB+UW-1:2*HB];
	end

endmodule

/* sv/skhc_blend.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip: blend and output
// Blends toward the clipped target by the weight, mixes with the original by
// the strength, and converts back to a saturated signed sample.
// ----------------------------------------------------------------------------
module skhc_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                v_in,
	input  logic [skhc_pkg::HB-1:0]             h_in,
	input  logic [skhc_pkg::UW-1:0]             w_in,
	input  skhc_pkg::cfg_t                      cfg,
	output logic                                v_out,
	output logic [skhc_pkg::SAMPLE_BITS-1:0]    sample
);
	import skhc_pkg::*;

	logic [UW-1:0]   hx;
	logic [UW-1:0]   wm;
	logic [UW-1:0]   target;
	logic [UW-1:0]   diff1;
	logic [2*UW-1:0] prod1;

	logic            v_s1, v_s2, v_s3;
	logic [UW-1:0]   h_s1, h_s2, h_s3;
	logic [UW-1:0]   a_s1;
	logic            neg_s1;
	logic [UW-1:0]   p_s1;
	logic [UW-1:0]   clip_s2;

	logic [UW-1:0]   diff2;
	logic [2*UW-1:0] prod2;
	logic            neg_s3;
	logic [UW-1:0]   p_s3;
	logic [UW-1:0]   r;

	assign hx = {1'b0, h_in};

	always_comb begin
		if (cfg.mode) begin
			wm     = w_in;
			target = (hx > cfg.thr) ? hx : cfg.thr;
		end else begin
			wm     = UNIT_ONE - w_in;
			target = (hx < cfg.thr) ? hx : cfg.thr;
		end
	end

	// The product is truncated toward the starting point of each blend.
	assign diff1 = (hx >= target) ? hx - target : target - hx;
	assign prod1 = diff1 * wm;
	assign diff2 = (clip_s2 >= h_s2) ? clip_s2 - h_s2 : h_s2 - clip_s2;
	assign prod2 = diff2 * cfg.str;
	assign r     = neg_s3 ? h_s3 - p_s3 : h_s3 + p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_out <= 1'b0;
		end else begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_out <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		h_s1    <= hx;
		a_s1    <= target;
		neg_s1  <= hx < target;
		p_s1    <= prod1[HB+UW-1:HB];
		h_s2    <= h_s1;
		clip_s2 <= neg_s1 ? a_s1 - p_s1 : a_s1 + p_s1;
		h_s3    <= h_s2;
		neg_s3  <= clip_s2 < h_s2;
		p_s3    <= prod2[HB+UW-1:HB];
		sample  <= to_sample(r);
	end

endmodule

/* sv/soft_knee_height_clip.sv */
// ----------------------------------------------------------------------------
// Soft knee height clip
// Smoothstep soft clip of signed height samples above or below a threshold,
// mixed with the original sample by a strength setting.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         start / busy         height_in
// result    out        done (strobe)        height_out
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample enters per clock and its result appears on done after the weight
// pipeline (entry, four divider stages, two multiplier stages) and the blend
// pipeline (the two blends and the output register).
// The divider and multipliers are fully pipelined, so busy stays low and a
// transaction may follow in every cycle. The result side cannot stall.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module soft_knee_height_clip (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [skhc_pkg::SAMPLE_BITS-1:0]    height_in,
	output logic                                done,
	output logic [skhc_pkg::SAMPLE_BITS-1:0]    height_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [skhc_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [skhc_pkg::REG_BITS-1:0]       cfg_data
);
	import skhc_pkg::*;

	cfg_t          cfg;
	logic          w_valid;
	logic [HB-1:0] w_h;
	logic [UW-1:0] w_w;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	skhc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	skhc_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (start & ~busy),
		.sample (height_in),
		.cfg    (cfg),
		.v_out  (w_valid),
		.h_out  (w_h),
		.w_out  (w_w)
	);

	skhc_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (w_valid),
		.h_in   (w_h),
		.w_in   (w_w),
		.cfg    (cfg),
		.v_out  (done),
		.sample (height_out)
	);

endmodule

/* bench/skhc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soft knee height clip: result checker
// Watches the sample, result and register channels of the clipper. It keeps
// its own copy of the registers and works out the clipped height for every
// accepted sample, then compares each result strobe with the oldest
// outstanding prediction in arrival order.
// ----------------------------------------------------------------------------
module skhc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [skhc_pkg::SAMPLE_BITS-1:0] height_in,
	input  logic                             done,
	input  logic [skhc_pkg::SAMPLE_BITS-1:0] height_out,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [skhc_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [skhc_pkg::REG_BITS-1:0]    cfg_data,
	output int                               pending,
	output int                               fail_count
);
	import skhc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int SHIFT_DOWN = (SB > 16) ? SB - 16 : 0;
	localparam int SHIFT_UP   = (SB < 16) ? 16 - SB : 0;
	localparam longint UNIT     = 65536;
	localparam longint REG_FULL = 32768;
	localparam longint HALF     = longint'(1) << (SB - 1);

	typedef struct {
		logic [SB-1:0] sample;
		logic [SB-1:0] height;
	} clipped_sample_t;

	clipped_sample_t clipped_q[$];

	logic                mode_r = 1'b0;
	logic [REG_BITS-1:0] thr_r  = THR_RESET;
	logic [REG_BITS-1:0] soft_r = SOFT_RESET;
	logic [REG_BITS-1:0] str_r  = STR_RESET;

	initial begin
		pending = 0;
		fail_count = 0;
	end

	// Moves a toward b by the fraction w of the gap, truncating toward a.
	function automatic longint mix_toward(input longint a, input longint b, input longint w);
		if (b >= a) begin
			return a + (((b - a) * w) >> 16);
		end
		return a - (((a - b) * w) >> 16);
	endfunction

	function automatic logic [SB-1:0] clip_height(input logic [SB-1:0] s);
		longint h, thr, knee, str, e0, den, t, w, target, clipped, r, u, val;
		h = (longint'(s ^ SB'(HALF)) >> SHIFT_DOWN) << SHIFT_UP;
		// Registers saturate at 1.0 before they are put on the 16-bit unit scale.
		thr  = (longint'(thr_r)  > REG_FULL ? REG_FULL : longint'(thr_r)) * 2;
		knee = (longint'(soft_r) > REG_FULL ? REG_FULL : longint'(soft_r));
		str  = (longint'(str_r)  > REG_FULL ? REG_FULL : longint'(str_r)) * 2;
		e0   = thr - knee;
		den  = knee * 2;
		if (den == 0) begin
			w = (h >= thr) ? UNIT : 0;
		end else begin
			if (h <= e0) begin
				t = 0;
			end else if (h - e0 >= den) begin
				t = UNIT;
			end else begin
				t = ((h - e0) << 16) / den;
			end
			w = (t * t * (3 * UNIT - 2 * t)) >> 32;
		end
		if (!mode_r) begin
			w = UNIT - w;
			target = (h < thr) ? h : thr;
		end else begin
			target = (h > thr) ? h : thr;
		end
		clipped = mix_toward(target, h, w);
		r = mix_toward(h, clipped, str);
		u = ((r + ((longint'(1) << SHIFT_UP) >> 1)) >> SHIFT_UP) << SHIFT_DOWN;
		val = u - HALF;
		if (val > HALF - 1) begin
			val = HALF - 1;
		end
		return val[SB-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clipped_sample_t oldest;
		if (!arst_n) begin
			mode_r = 1'b0;
			thr_r  = THR_RESET;
			soft_r = SOFT_RESET;
			str_r  = STR_RESET;
			clipped_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (clipped_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: result %h with no sample outstanding", $realtime,
							height_out);
					end
					fail_count++;
				end else begin
					oldest = clipped_q.pop_front();
					if (height_out !== oldest.height) begin
						if (fail_count < 10) begin
							$display("%0t: height_in %h expected %h got %h", $realtime,
								oldest.sample, oldest.height, height_out);
						end
						fail_count++;
					end
				end
			end
			// The prediction uses the registers as they stood before this edge.
			if (start && !busy) begin
				clipped_q.push_back('{sample: height_in, height: clip_height(height_in)});
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_r = cfg_data[0];
					REG_THR:  thr_r  = cfg_data;
					REG_SOFT: soft_r = cfg_data;
					REG_STR:  str_r  = cfg_data;
					default: ;
				endcase
			end
			pending <= clipped_q.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soft knee height clip: testbench top
// Drives height samples and register writes into the clipper. A short
// directed run covers the sample extremes, the knee edges, the hard step
// and saturated registers; random phases follow with varied settings and
// sender gaps. The checker alongside predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import skhc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 175;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [SB-1:0]          height_in;
	logic                   done;
	logic [SB-1:0]          height_out;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_BITS-1:0]    cfg_index;
	logic [REG_BITS-1:0]    cfg_data;
	int                     pending;
	int                     fail_count;
	int                     cycle_count;

	int idle_pct;
	int thr_set;
	int soft_set;

	int default_knee_pts[11] = '{-32768, 32767, 0, -1, 1, -3277, 3277, -3278, 3278, 100, -100};
	int hard_step_pts[5]     = '{0, -1, 1, 32767, -32768};
	int saturated_pts[4]     = '{-32768, 32767, 0, 16};
	int idle_plan[3]         = '{0, 81, 9};

	soft_knee_height_clip DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.height_in  (height_in),
		.done       (done),
		.height_out (height_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	skhc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.height_in  (height_in),
		.done       (done),
		.height_out (height_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Holds the sample until a transaction takes place; start stays high if
	// the next sample follows without a gap.
	task automatic send_height(input int v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		height_in <= SB'(v);
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= REG_BITS'(data);
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers are only written once every outstanding result has come back.
	task automatic load_settings(input int mode_data, input int thr, input int soft_in,
			input int str);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		write_reg(REG_MODE, mode_data);
		write_reg(REG_THR, thr);
		write_reg(REG_SOFT, soft_in);
		write_reg(REG_STR, str);
		cfg_valid <= 1'b0;
		thr_set = thr;
		soft_set = soft_in;
	endtask

	initial begin
		int centre, span, v;
		arst_n = 1'b0;
		start = 1'b0;
		height_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		thr_set = 16384;
		soft_set = 3277;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: sample extremes and both edges of the knee.
		foreach (default_knee_pts[i]) begin
			send_height(default_knee_pts[i]);
		end
		// Zero softness gives a hard step exactly at the threshold, in both modes.
		load_settings(1, 16384, 0, 32768);
		foreach (hard_step_pts[i]) begin
			send_height(hard_step_pts[i]);
		end
		load_settings(0, 16384, 0, 32768);
		foreach (hard_step_pts[i]) begin
			send_height(hard_step_pts[i]);
		end
		// Threshold, softness and strength all above 1.0, so each one saturates.
		load_settings(1, 65535, 65535, 65535);
		foreach (saturated_pts[i]) begin
			send_height(saturated_pts[i]);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: load_settings(0, 16384, 3277, 32768);
				1: load_settings(1, 0, 0, 32768);
				2: load_settings(0, 32768, 32768, 0);
				3: load_settings(1, 65535, 65535, 65535);
				4: load_settings(0, 0, 32768, 16384);
				default: load_settings($urandom_range(0, 65535),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 32768),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 8192),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 32768));
			endcase
			idle_pct = idle_plan[phase % 3];
			centre = 2 * ((thr_set > 32768) ? 32768 : thr_set) - 32768;
			span = ((soft_set > 32768) ? 32768 : soft_set) + 4;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Samples near the knee are where the smoothstep does its work.
				if ($urandom_range(0, 9) < 4) begin
					v = centre + $urandom_range(0, 2 * span) - span;
					if (v > 32767) begin
						v = 32767;
					end else if (v < -32768) begin
						v = -32768;
					end
				end else begin
					v = $urandom_range(0, 65535);
				end
				send_height(v);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
